>>> hw/rtl/acd_pkg.sv
// Shared types, constants and the reciprocal table for the alpha color dilate block.
// No dependencies; every other file but acd_ram and acd_checker imports this package.
package acd_pkg;

	localparam int PIX_W = 32;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int RECIP_W = 15;
	localparam int RECIP_SHIFT = 14;

	localparam logic [PIX_W-1:0] ALPHA_MASK = 32'hff00_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;

	typedef enum logic [1:0] {
		CH_0,
		CH_1,
		CH_2
	} chan_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic sum;
		logic div;
		chan_t chan;
		logic put;
	} acd_cmd_t;

	typedef struct packed {
		logic emit;
		logic busy;
		logic out_free;
	} acd_sts_t;

	// ceil(2^14 / n); exact truncating division for any sum of n 8-bit channels.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			4'd1: r = 15'd16384;
			4'd2: r = 15'd8192;
			4'd3: r = 15'd5462;
			4'd4: r = 15'd4096;
			4'd5: r = 15'd3277;
			4'd6: r = 15'd2731;
			4'd7: r = 15'd2341;
			4'd8: r = 15'd2048;
			4'd9: r = 15'd1821;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/acd_in_if.sv
// Input channel of the alpha color dilate block: one pixel or drain word per handshake.
// Depends on acd_pkg.
interface acd_in_if;
	import acd_pkg::*;

	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel_in;
	logic drain;

	modport source(output valid, pixel_in, drain, input ready);
	modport sink(input valid, pixel_in, drain, output ready);
endinterface

>>> hw/rtl/acd_out_if.sv
// Output channel of the alpha color dilate block: one processed pixel word per handshake.
// Depends on acd_pkg.
interface acd_out_if;
	import acd_pkg::*;

	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel_out;
	logic frame_last;

	modport source(output valid, pixel_out, frame_last, input ready);
	modport sink(input valid, pixel_out, frame_last, output ready);
endinterface

>>> hw/rtl/alpha_color_dilate_3x3.sv
// Top level of the alpha color dilate block: controller, datapath and channel wiring.
// Depends on acd_pkg, acd_in_if, acd_out_if, acd_ctrl and acd_datapath.
//
//   Channel   Dir   Word                       Handshake
//   pixels    in    pixel_in[31:0], drain      valid / ready
//   results   out   pixel_out[31:0], frame_last valid / ready
//   cfg       in    cfg_index, cfg_data[15:0]  cfg_we, no back-pressure
//
// An item that yields no result passes through accept and line store read only; one
// that yields a result goes on through window sum, three channel divides through one
// shared reciprocal multiplier and output load, and may wait for the output register.
// A write of image_width starts a bit-serial position divider; no word is accepted
// until it finishes. Reset is asynchronous and needs no clearing pass.
// A stalled output holds its word while the next input word is already taken.
module alpha_color_dilate_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	acd_in_if.sink                         pixels,
	acd_out_if.source                      results,
	input  logic                           cfg_we,
	input  logic [acd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acd_pkg::*;

	acd_cmd_t cmd;
	acd_sts_t sts;

	acd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pixels.valid),
		.in_ready(pixels.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	acd_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pixel_in  (pixels.pixel_in),
		.drain     (pixels.drain),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.pixel_out (results.pixel_out),
		.frame_last(results.frame_last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule

>>> hw/rtl/acd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module acd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> hw/rtl/acd_ctrl.sv
// Controller state machine of the alpha color dilate block.
// Depends on acd_pkg; drives the datapath through acd_cmd_t and reads acd_sts_t.
module acd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  acd_pkg::acd_sts_t  sts,
	output acd_pkg::acd_cmd_t  cmd
);
	import acd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_DIV2,
		ST_DIV1,
		ST_DIV0,
		ST_PUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE) && !sts.busy;

	always_comb begin
		cmd = '0;
		cmd.chan = CH_0;
		unique case (state_q)
			ST_IDLE: cmd.accept = in_valid && in_ready;
			ST_LOAD: cmd.load = 1'b1;
			ST_SUM:  cmd.sum = 1'b1;
			ST_DIV2: begin
				cmd.div = 1'b1;
				cmd.chan = CH_2;
			end
			ST_DIV1: begin
				cmd.div = 1'b1;
				cmd.chan = CH_1;
			end
			ST_DIV0: begin
				cmd.div = 1'b1;
				cmd.chan = CH_0;
			end
			ST_PUT:  cmd.put = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= sts.emit ? ST_SUM : ST_IDLE;
				ST_SUM:  state_q <= ST_DIV2;
				ST_DIV2: state_q <= ST_DIV1;
				ST_DIV1: state_q <= ST_DIV0;
				ST_DIV0: state_q <= ST_PUT;
				ST_PUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/acd_datapath.sv
// Datapath of the alpha color dilate block: line stores, 3x3 window, counters,
// channel averaging with a shared reciprocal multiplier, position divider, output register.
// Depends on acd_pkg and acd_ram.
module acd_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  acd_pkg::acd_cmd_t             cmd,
	output acd_pkg::acd_sts_t             sts,
	input  logic [acd_pkg::PIX_W-1:0]      pixel_in,
	input  logic                          drain,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [acd_pkg::PIX_W-1:0]      pixel_out,
	output logic                          frame_last,
	input  logic                          cfg_we,
	input  logic [acd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acd_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int EWW = $clog2(MAX_WIDTH + 1);
	localparam int PW = XW + HEIGHT_W;
	localparam int DCW = $clog2(PW);
	localparam int PRODW = SUM_W + RECIP_W;

	logic [WIDTH_W-1:0] cfg_w_q;
	logic [HEIGHT_W-1:0] cfg_h_q;
	logic [EWW-1:0] ew;
	logic [HEIGHT_W-1:0] eh;
	logic [EWW+HEIGHT_W-1:0] tot_full;
	logic [PW-1:0] total_q;

	logic [XW-1:0] col_q, cx_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [PW-1:0] pos_q, cy_q;
	logic [XW-1:0] col_w;
	logic [HEIGHT_W-1:0] row_w;
	logic col_wrap;
	logic [PIX_W-1:0] px_m, px_q;
	logic emit_c, emit_q;

	logic [PIX_W-1:0] up_rd, mid_rd;
	logic [PIX_W-1:0] win_q [9];

	logic top_clip, bot_clip, left_clip, right_clip;
	logic [SUM_W-1:0] s2_c, s1_c, s0_c, s2_q, s1_q, s0_q;
	logic [CNT_W-1:0] n_c, n_q;
	logic pass_q, last_c, last_q;
	logic [PIX_W-1:0] centre_q;

	logic [SUM_W-1:0] sum_sel;
	logic [PRODW-1:0] prod_c;
	logic [7:0] q_c, q2_q, q1_q, q0_q;

	logic out_free;
	logic out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_pix_q;

	logic pend_q;
	logic [DCW-1:0] dv_cnt_q;
	logic [EWW-1:0] dv_rem_q;
	logic [PW-1:0] dv_quo_q;
	logic [EWW:0] dv_sh;
	logic dv_ge;
	logic [EWW-1:0] dv_rem_nx;
	logic [PW-1:0] dv_quo_nx;
	logic width_wr;

	// Effective geometry.
	always_comb begin
		if (cfg_w_q == '0) begin
			ew = EWW'(1);
		end else if (32'(cfg_w_q) > MAX_WIDTH) begin
			ew = EWW'(MAX_WIDTH);
		end else begin
			ew = EWW'(cfg_w_q);
		end
		eh = (cfg_h_q == '0) ? HEIGHT_W'(1) : cfg_h_q;
	end

	assign tot_full = (EWW + HEIGHT_W)'(ew) * (EWW + HEIGHT_W)'(eh);
	assign width_wr = cfg_we && (cfg_index == CFG_IMAGE_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= WIDTH_RESET;
			cfg_h_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IMAGE_WIDTH) begin
				cfg_w_q <= cfg_data[WIDTH_W-1:0];
			end
			if (cfg_index == CFG_IMAGE_HEIGHT) begin
				cfg_h_q <= cfg_data[HEIGHT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		total_q <= tot_full[PW-1:0];
	end

	// Input position, wrapped at the start of the word.
	always_comb begin
		col_wrap = EWW'(col_q) >= ew;
		col_w = col_wrap ? '0 : col_q;
		row_w = col_wrap ? row_q + HEIGHT_W'(1) : row_q;
		px_m = (drain || (row_w >= eh)) ? '0 : pixel_in;
		emit_c = (pos_q != '0) || (row_w >= HEIGHT_W'(2))
			|| ((row_w == HEIGHT_W'(1)) && (col_w != '0));
	end

	acd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(col_q),
		.wdata(mid_rd),
		.re   (cmd.accept),
		.raddr(col_w),
		.rdata(up_rd)
	);

	acd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(col_q),
		.wdata(px_q),
		.re   (cmd.accept),
		.raddr(col_w),
		.rdata(mid_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= px_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				emit_q <= emit_c;
			end
			if (cmd.load) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= up_rd;
				win_q[5] <= mid_rd;
				win_q[8] <= px_q;
			end
		end
	end

	// Channel sums over the opaque pixels of the clipped window.
	always_comb begin
		top_clip = cy_q == '0;
		bot_clip = ({1'b0, cy_q} + (PW + 1)'(1)) >= (PW + 1)'(eh);
		left_clip = cx_q == '0;
		right_clip = (EWW'(cx_q) + EWW'(1)) >= ew;
		last_c = ({1'b0, pos_q} + (PW + 1)'(1)) >= {1'b0, total_q};
		s2_c = '0;
		s1_c = '0;
		s0_c = '0;
		n_c = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!((r == 0) && top_clip) && !((r == 2) && bot_clip)
					&& !((c == 0) && left_clip) && !((c == 2) && right_clip)
					&& ((win_q[r*3+c] & ALPHA_MASK) != '0)) begin
					s2_c = s2_c + SUM_W'(win_q[r*3+c][23:16]);
					s1_c = s1_c + SUM_W'(win_q[r*3+c][15:8]);
					s0_c = s0_c + SUM_W'(win_q[r*3+c][7:0]);
					n_c = n_c + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			s2_q <= s2_c;
			s1_q <= s1_c;
			s0_q <= s0_c;
			n_q <= n_c;
			pass_q <= (win_q[4] & ALPHA_MASK) != '0;
			centre_q <= win_q[4];
			last_q <= last_c;
		end
	end

	// One channel per cycle through the reciprocal multiplier.
	always_comb begin
		unique case (cmd.chan)
			CH_2: sum_sel = s2_q;
			CH_1: sum_sel = s1_q;
			CH_0: sum_sel = s0_q;
			default: sum_sel = '0;
		endcase
		prod_c = PRODW'(sum_sel) * PRODW'(recip(n_q));
		q_c = prod_c[RECIP_SHIFT+7:RECIP_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			unique case (cmd.chan)
				CH_2: q2_q <= q_c;
				CH_1: q1_q <= q_c;
				CH_0: q0_q <= q_c;
				default: ;
			endcase
		end
	end

	// Restoring division of the output position by the width after a width change.
	always_comb begin
		dv_sh = {dv_rem_q, dv_quo_q[PW-1]};
		dv_ge = dv_sh >= {1'b0, ew};
		dv_rem_nx = dv_ge ? EWW'(dv_sh - {1'b0, ew}) : EWW'(dv_sh);
		dv_quo_nx = {dv_quo_q[PW-2:0], dv_ge};
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			pend_q <= 1'b0;
			dv_cnt_q <= '0;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else begin
			if (cmd.accept) begin
				col_q <= col_w;
				row_q <= row_w;
			end
			if (cmd.load) begin
				if ((EWW'(col_q) + EWW'(1)) >= ew) begin
					col_q <= '0;
					row_q <= row_q + HEIGHT_W'(1);
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
			if (cmd.put && out_free) begin
				if (last_q) begin
					col_q <= '0;
					row_q <= '0;
					pos_q <= '0;
					cx_q <= '0;
					cy_q <= '0;
				end else begin
					pos_q <= pos_q + PW'(1);
					if ((EWW'(cx_q) + EWW'(1)) >= ew) begin
						cx_q <= '0;
						cy_q <= cy_q + PW'(1);
					end else begin
						cx_q <= cx_q + XW'(1);
					end
				end
			end
			if (width_wr) begin
				pend_q <= 1'b1;
				dv_cnt_q <= '0;
				dv_rem_q <= '0;
				dv_quo_q <= pos_q;
			end else if (pend_q) begin
				dv_rem_q <= dv_rem_nx;
				dv_quo_q <= dv_quo_nx;
				dv_cnt_q <= dv_cnt_q + DCW'(1);
				if (dv_cnt_q == DCW'(PW - 1)) begin
					pend_q <= 1'b0;
					cx_q <= XW'(dv_rem_nx);
					cy_q <= dv_quo_nx;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put && out_free) begin
			out_pix_q <= pass_q ? centre_q : {8'h00, q2_q, q1_q, q0_q};
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = out_pix_q;
	assign frame_last = out_last_q;

	assign sts.emit = emit_q;
	assign sts.busy = pend_q;
	assign sts.out_free = out_free;
endmodule

>>> hw/rtl/acd_checker.sv
// Port-level checks for the alpha color dilate block, bound to its top level.
// No package dependency; sees only the top-level ports.
module acd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pixel_out,
	input logic        frame_last
);
	// A stalled result word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_last))
		else $error("result word changed while stalled");

	// One word is processed at a time, so ready drops right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again while a word is in work");

	// A new result only appears out of the busy phase of an item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");
endmodule

bind alpha_color_dilate_3x3 acd_checker u_acd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.pixel_out (results.pixel_out),
	.frame_last(results.frame_last)
);
